// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, codes and the CRC-16 byte update for the sync frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Frame parser phases
  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhCmd     = 3'd1;
  localparam logic [2:0] PhLenLo   = 3'd2;
  localparam logic [2:0] PhLenHi   = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhCrcLo   = 3'd5;
  localparam logic [2:0] PhCrcHi   = 3'd6;

  // Result event codes
  localparam logic [1:0] EvPayload = 2'd0;
  localparam logic [1:0] EvGood    = 2'd1;
  localparam logic [1:0] EvBadCrc  = 2'd2;
  localparam logic [1:0] EvTimeout = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgSyncMin  = 2'd0;
  localparam logic [1:0] CfgCommand  = 2'd1;
  localparam logic [1:0] CfgLength   = 2'd2;
  localparam logic [1:0] CfgTimeout  = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  SyncMinRst  = 8'd3;
  localparam logic [7:0]  CommandRst  = 8'hEE;
  localparam logic [15:0] LengthRst   = 16'd2052;
  localparam logic [19:0] TimeoutRst  = 20'd700000;

  // Framing bytes and CRC polynomial
  localparam logic [7:0]  SyncByte = 8'hAA;
  localparam logic [7:0]  MarkByte = 8'h00;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  typedef struct packed {
    logic [7:0]  sync_min;
    logic [7:0]  command_code;
    logic [15:0] frame_length;
    logic [19:0] timeout_ticks;
  } sfr_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
  } sfr_res_t;

  // CRC-16/XMODEM update with one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/sfr_core.sv =====
// ----------------------------------------------------------------------------
// sfr_core
// Frame parser state, CRC accumulator and idle counter; one item per cycle while items are accepted.
// ----------------------------------------------------------------------------
module sfr_core import sfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       req_type_i,
  input  logic [7:0] rx_byte_i,
  input  sfr_cfg_t   cfg_i,
  output sfr_res_t   res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  sync_seen_q, sync_seen_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] left_q, left_d;
  logic [15:0] offset_q, offset_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [19:0] idle_q, idle_d;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] left_dec;

  assign crc_upd  = crc16_byte((phase_q == PhCmd) ? 16'h0000 : crc_q, rx_byte_i);
  assign len_full = {rx_byte_i, left_q[7:0]};
  assign left_dec = left_q - 16'd1;

  // Next state and result for the item at the input
  always_comb begin
    phase_d     = phase_q;
    sync_seen_d = sync_seen_q;
    crc_d       = crc_q;
    left_d      = left_q;
    offset_d    = offset_q;
    crc_lo_d    = crc_lo_q;
    idle_d      = idle_q;
    res_o       = '0;

    if (req_type_i) begin
      // idle tick
      if (idle_q >= cfg_i.timeout_ticks) begin
        idle_d           = '0;
        phase_d          = PhHunt;
        sync_seen_d      = '0;
        res_o.valid      = 1'b1;
        res_o.event_kind = EvTimeout;
      end else begin
        idle_d = idle_q + 20'd1;
      end
    end else begin
      idle_d = '0;
      case (phase_q)
        PhCmd: begin
          crc_d   = crc_upd;
          phase_d = (rx_byte_i == cfg_i.command_code) ? PhLenLo : PhHunt;
        end
        PhLenLo: begin
          left_d  = {8'h00, rx_byte_i};
          crc_d   = crc_upd;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          left_d   = len_full;
          crc_d    = crc_upd;
          offset_d = '0;
          if (len_full != cfg_i.frame_length) begin
            phase_d = PhHunt;
          end else if (len_full == 16'd0) begin
            phase_d = PhCrcLo;
          end else begin
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          offset_d             = offset_q + 16'd1;
          crc_d                = crc_upd;
          left_d               = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PhCrcLo;
          end
          res_o.valid          = 1'b1;
          res_o.event_kind     = EvPayload;
          res_o.payload_byte   = rx_byte_i;
          res_o.payload_offset = offset_q;
        end
        PhCrcLo: begin
          crc_lo_d = rx_byte_i;
          phase_d  = PhCrcHi;
        end
        PhCrcHi: begin
          phase_d          = PhHunt;
          res_o.valid      = 1'b1;
          res_o.event_kind = ({rx_byte_i, crc_lo_q} == crc_q) ? EvGood : EvBadCrc;
        end
        default: begin
          // hunting, also the unused phase code
          phase_d = PhHunt;
          if (rx_byte_i == SyncByte) begin
            if (sync_seen_q != 8'hFF) begin
              sync_seen_d = sync_seen_q + 8'd1;
            end
          end else begin
            if (rx_byte_i == MarkByte && sync_seen_q >= cfg_i.sync_min) begin
              phase_d = PhCmd;
            end
            sync_seen_d = '0;
          end
        end
      endcase
    end

    if (!accept_i) begin
      res_o.valid = 1'b0;
    end
  end

  // State registers, updated only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      sync_seen_q <= '0;
      crc_q       <= '0;
      left_q      <= '0;
      offset_q    <= '0;
      crc_lo_q    <= '0;
      idle_q      <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      sync_seen_q <= sync_seen_d;
      crc_q       <= crc_d;
      left_q      <= left_d;
      offset_q    <= offset_d;
      crc_lo_q    <= crc_lo_d;
      idle_q      <= idle_d;
    end
  end

endmodule

// ===== rtl/sfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// sfr_out_reg
// Result register holding one item until the consumer takes it.
// ----------------------------------------------------------------------------
module sfr_out_reg import sfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sfr_res_t res_i,
  input  logic     out_ready_i,
  output logic     load_ok_o,
  output logic     out_valid_o,
  output sfr_res_t res_o
);

  logic     valid_q, valid_d;
  sfr_res_t data_q;

  // Register may load when empty or being drained this cycle
  assign load_ok_o = !valid_q || out_ready_i;
  assign valid_d   = load_ok_o ? res_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_ok_o && res_i.valid) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = data_q;

endmodule

// ===== rtl/sync_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16
// Sync-hunting frame receiver with command/length check, payload streaming
// and CRC-16/XMODEM verification.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid_i/in_ready_o | req_type_i, rx_byte_i
//  out     | output    | out_valid_o/out_ready_i | event_kind_o, payload_byte_o,
//          |           |                       | payload_offset_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One item per cycle while in_ready_o is high: the parser updates in the accept
//  cycle and its result, if any, appears in the output register on the next cycle.
//  in_ready_o is high whenever the output register is empty or being drained.
//  Reset clears the parser to hunting and loads the default configuration;
//  cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc16 import sfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_offset_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  sfr_cfg_t cfg_q;
  sfr_res_t core_res;
  sfr_res_t out_res;
  logic     load_ok;
  logic     accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = load_ok;
  assign accept      = in_valid_i && load_ok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_min      <= SyncMinRst;
      cfg_q.command_code  <= CommandRst;
      cfg_q.frame_length  <= LengthRst;
      cfg_q.timeout_ticks <= TimeoutRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSyncMin: cfg_q.sync_min      <= cfg_data_i[7:0];
        CfgCommand: cfg_q.command_code  <= cfg_data_i[7:0];
        CfgLength:  cfg_q.frame_length  <= cfg_data_i[15:0];
        CfgTimeout: cfg_q.timeout_ticks <= cfg_data_i;
        default:    cfg_q.timeout_ticks <= cfg_q.timeout_ticks;
      endcase
    end
  end

  sfr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg_q),
    .res_o      (core_res)
  );

  sfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (core_res),
    .out_ready_i (out_ready_i),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign event_kind_o     = out_res.event_kind;
  assign payload_byte_o   = out_res.payload_byte;
  assign payload_offset_o = out_res.payload_offset;

endmodule
